// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/lms_pkg.sv =====
// constants, state codes and saturation helper for the lms linear trainer
// no dependencies
`default_nettype none

package lms_pkg;

	localparam int MAX_FEATURES = 16;
	localparam int FEATURE_BITS = 16;
	localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int POS_W = $clog2(MAX_FEATURES + 1);
	localparam int MUL_W = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W = 64;
	localparam int COST_W = 48;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FEATURES_IN_USE = 2'd3;

	localparam logic [15:0] RATE_RESET = 16'd655;
	localparam logic [30:0] TOL_RESET = 31'd1;
	localparam logic [4:0] FIU_RESET = 5'd16;

	localparam logic signed [PROD_W-1:0] I32_MAX = PROD_W'(64'sd2147483647);
	localparam logic signed [PROD_W-1:0] I32_MIN = PROD_W'(-64'sd2147483648);

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_ACC  = 10'b00_0000_0010,
		S_PRED = 10'b00_0000_0100,
		S_ERR  = 10'b00_0000_1000,
		S_MAG  = 10'b00_0001_0000,
		S_STEP = 10'b00_0010_0000,
		S_COST = 10'b00_0100_0000,
		S_WMUL = 10'b00_1000_0000,
		S_WUPD = 10'b01_0000_0000,
		S_FIN  = 10'b10_0000_0000
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [31:0] r;
		if (v > I32_MAX)
			r = 32'h7fff_ffff;
		else if (v < I32_MIN)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lms_linear_trainer.sv =====
// lms linear trainer top level: sequencer, shared multiplier, weights and cost state
// depends on lms_pkg
`default_nettype none

// Features arrive one per input transaction and are buffered up to the feature count;
// each is accepted, then weight times feature is summed through the shared multiplier.
// A feature marked last_feature then runs a further sequence: the same multiplier is
// reused in turn for the rate-error step, the squared error and, when the error exceeds
// tolerance, one weight update per buffered feature; the squared error sets the cost of
// a sample. in_stall is high for the whole sequence, and the final state also waits
// while an earlier result is still held in the output register. One result transaction
// per last_feature item; pass_cost and cost_settled are nonzero only on the last sample
// of a pass.

module lms_linear_trainer import lms_pkg::*; (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [FEATURE_BITS-1:0] feature_value,
	input  wire logic signed [15:0]             target,
	input  wire logic                           last_feature,
	input  wire logic                           last_sample,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [31:0]                  prediction,
	output logic signed [31:0]                  error,
	output logic                                weights_updated,
	output logic [31:0]                         update_count,
	output logic [COST_W-1:0]                   pass_cost,
	output logic                                cost_settled,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [31:0]                    cfg_data
);

	state_t state_q;

	logic [15:0] rate_q;
	logic [30:0] tol_q;
	logic signed [31:0] bias_q;
	logic [4:0] fiu_q;

	logic signed [FEATURE_BITS-1:0] buf_q [MAX_FEATURES];
	logic signed [31:0] w_q [MAX_FEATURES];

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] walk_q;
	logic [ACC_W-1:0] acc_q;
	logic [COST_W-1:0] run_cost_q;
	logic [COST_W-1:0] prev_cost_q;
	logic [31:0] upd_cnt_q;

	logic hit_q;
	logic lastf_q;
	logic lasts_q;
	logic signed [15:0] tgt_q;
	logic signed [31:0] pred_q;
	logic signed [31:0] err_q;
	logic [31:0] mag_q;
	logic signed [31:0] step_q;
	logic upd_q;

	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_q;

	logic out_valid_q;
	logic out_free;
	logic in_acc;
	logic [POS_W-1:0] n_eff;
	logic [IDX_W-1:0] pos_idx;
	logic [IDX_W-1:0] walk_idx;

	logic [ACC_W-1:0] pred_sum;
	logic signed [PROD_W-1:0] pred_shift;
	logic signed [PROD_W-1:0] err_wide;
	logic [COST_W-2:0] sq;
	logic [COST_W:0] cost_sum;
	logic [COST_W-1:0] cost_diff;
	logic signed [PROD_W-1:0] w_sum;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign pos_idx = pos_q[IDX_W-1:0];
	assign walk_idx = walk_q[IDX_W-1:0];

	always_comb begin
		if (fiu_q == 5'd0)
			n_eff = POS_W'(1);
		else if (32'(fiu_q) > MAX_FEATURES)
			n_eff = POS_W'(MAX_FEATURES);
		else
			n_eff = POS_W'(fiu_q);
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_IDLE: begin
				mul_a = MUL_W'(feature_value);
				mul_b = MUL_W'(w_q[pos_idx]);
			end
			S_MAG: begin
				mul_a = MUL_W'({1'b0, rate_q});
				mul_b = MUL_W'(err_q);
			end
			S_STEP: begin
				mul_a = MUL_W'({1'b0, mag_q});
				mul_b = MUL_W'({1'b0, mag_q});
			end
			S_WMUL: begin
				mul_a = MUL_W'(step_q);
				mul_b = MUL_W'(buf_q[walk_idx]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign pred_sum = acc_q + {{(ACC_W-40){bias_q[31]}}, bias_q, 8'h00};
	assign pred_shift = PROD_W'($signed(pred_sum) >>> 8);
	assign err_wide = PROD_W'($signed({{9{tgt_q[15]}}, tgt_q, 8'h00})) - PROD_W'(pred_q);
	assign sq = prod_q[COST_W+15:17];
	assign cost_sum = {1'b0, run_cost_q} + {2'b00, sq};
	assign cost_diff = (run_cost_q >= prev_cost_q) ? (run_cost_q - prev_cost_q)
		: (prev_cost_q - run_cost_q);
	assign w_sum = PROD_W'(w_q[walk_idx]) + (prod_q >>> 8);

	// sample buffer and per-item payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (pos_q < n_eff)
				buf_q[pos_idx] <= feature_value;
			tgt_q <= target;
			lastf_q <= last_feature;
			lasts_q <= last_sample;
		end
		case (state_q)
			S_PRED: pred_q <= sat32(pred_shift);
			S_ERR: err_q <= sat32(err_wide);
			S_MAG: mag_q <= err_q[31] ? (~err_q + 32'd1) : err_q;
			S_STEP: begin
				step_q <= prod_q[47:16];
				upd_q <= (mag_q > {1'b0, tol_q});
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rate_q <= RATE_RESET;
			tol_q <= TOL_RESET;
			bias_q <= '0;
			fiu_q <= FIU_RESET;
			for (int k = 0; k < MAX_FEATURES; k++)
				w_q[k] <= '0;
			pos_q <= '0;
			walk_q <= '0;
			acc_q <= '0;
			run_cost_q <= '0;
			prev_cost_q <= '0;
			upd_cnt_q <= '0;
			hit_q <= 1'b0;
			out_valid_q <= 1'b0;
			prediction <= '0;
			error <= '0;
			weights_updated <= 1'b0;
			update_count <= '0;
			pass_cost <= '0;
			cost_settled <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LEARNING_RATE: rate_q <= cfg_data[15:0];
					CFG_TOLERANCE: tol_q <= cfg_data[30:0];
					CFG_BIAS: bias_q <= cfg_data;
					CFG_FEATURES_IN_USE: fiu_q <= cfg_data[4:0];
					default: begin
					end
				endcase
			end
			// the final state reloads the output register itself
			if (out_valid_q && !out_stall && state_q != S_FIN)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						hit_q <= (pos_q < n_eff);
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (hit_q) begin
						acc_q <= acc_q + prod_q[ACC_W-1:0];
						pos_q <= pos_q + POS_W'(1);
					end
					state_q <= lastf_q ? S_PRED : S_IDLE;
				end
				S_PRED: state_q <= S_ERR;
				S_ERR: state_q <= S_MAG;
				S_MAG: state_q <= S_STEP;
				S_STEP: state_q <= S_COST;
				S_COST: begin
					run_cost_q <= cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
					if (upd_q && upd_cnt_q != 32'hffff_ffff)
						upd_cnt_q <= upd_cnt_q + 32'd1;
					walk_q <= '0;
					state_q <= (upd_q && pos_q != '0) ? S_WMUL : S_FIN;
				end
				S_WMUL: state_q <= S_WUPD;
				S_WUPD: begin
					w_q[walk_idx] <= sat32(w_sum);
					walk_q <= walk_q + POS_W'(1);
					state_q <= ((walk_q + POS_W'(1)) < pos_q) ? S_WMUL : S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						prediction <= pred_q;
						error <= err_q;
						weights_updated <= upd_q;
						update_count <= upd_cnt_q;
						if (lasts_q) begin
							pass_cost <= run_cost_q;
							cost_settled <= (cost_diff <= COST_W'(tol_q));
							prev_cost_q <= run_cost_q;
							run_cost_q <= '0;
						end else begin
							pass_cost <= '0;
							cost_settled <= 1'b0;
						end
						pos_q <= '0;
						acc_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lms_checker.sv =====
// port-level checker for the lms linear trainer, bound to the top level
// depends on assert_macros.svh and lms_pkg
`default_nettype none

`include "assert_macros.svh"

module lms_checker import lms_pkg::*; (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic signed [31:0]             prediction,
	input wire logic signed [31:0]             error,
	input wire logic                           weights_updated,
	input wire logic [31:0]                    update_count,
	input wire logic [COST_W-1:0]              pass_cost,
	input wire logic                           cost_settled
);

	logic [COST_W+97:0] out_word;

	assign out_word = {prediction, error, weights_updated, update_count, pass_cost,
		cost_settled};

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_word))
	// every accepted transaction makes the block busy in the next cycle
	`ASSERT_NEXT(a_in_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	// an update is always counted
	`ASSERT_NOW(a_upd_count, clk, arst_n, out_valid && weights_updated, update_count != 32'd0)

endmodule

bind lms_linear_trainer lms_checker u_lms_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for lms_linear_trainer: a directed table, then randomized training passes
// results are checked against a fixed-point predictor kept in this file; depends on lms_pkg

module tb;
	import lms_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 48;
	localparam int RANDOM_ITEMS = 1530;
	localparam logic [COST_W-1:0] COST_FULL = '1;

	typedef struct packed {
		logic signed [31:0] prediction;
		logic signed [31:0] error;
		logic               weights_updated;
		logic [31:0]        update_count;
		logic [COST_W-1:0]  pass_cost;
		logic               cost_settled;
	} trainer_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_index;
		logic [31:0]            reg_data;
		logic [15:0]            feature;
		logic [15:0]            target;
		logic                   last_f;
		logic                   last_s;
		logic                   typed;
		trainer_result_t        result;
	} plan_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic signed [FEATURE_BITS-1:0] feature_value = '0;
	logic signed [15:0]             target = '0;
	logic                           last_feature = 1'b0;
	logic                           last_sample = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic signed [31:0]             prediction;
	logic signed [31:0]             error;
	logic                           weights_updated;
	logic [31:0]                    update_count;
	logic [COST_W-1:0]              pass_cost;
	logic                           cost_settled;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [CFG_IDX_W-1:0]           cfg_index = '0;
	logic [31:0]                    cfg_data = '0;

	lms_linear_trainer dut (.*);

	always #10 clk = ~clk;

	// predictor state and register copies
	logic [15:0]               m_rate = RATE_RESET;
	logic [30:0]               m_tol = TOL_RESET;
	logic signed [31:0]        m_bias = '0;
	logic [4:0]                m_fiu = FIU_RESET;
	logic signed [15:0]        m_buffer [MAX_FEATURES];
	logic signed [31:0]        m_weight [MAX_FEATURES] = '{default: '0};
	int                        m_pos = 0;
	logic [63:0]               m_dot = '0;
	logic [COST_W-1:0]         m_run_cost = '0;
	logic [COST_W-1:0]         m_prev_cost = '0;
	logic [31:0]               m_updates = '0;

	trainer_result_t expected_results [$];
	plan_row_t       directed_plan [$];
	bit              burst_mode = 1'b0;
	int              mismatches = 0;
	int              items_sent = 0;
	int              results_seen = 0;
	int              reg_writes = 0;
	int              random_items = 0;
	int              idle_cycles = 0;
	int              sink_hold = 0;

	function automatic longint clamp_word(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic int clamped_count();
		if (m_fiu == 0)
			return 1;
		if (m_fiu > MAX_FEATURES)
			return MAX_FEATURES;
		return m_fiu;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		case (idx)
			CFG_LEARNING_RATE: m_rate = data[15:0];
			CFG_TOLERANCE: m_tol = data[30:0];
			CFG_BIAS: m_bias = data;
			CFG_FEATURES_IN_USE: m_fiu = data[4:0];
			default: ;
		endcase
	endfunction

	task automatic train_step(input logic signed [15:0] fv, input logic signed [15:0] tgt,
			input logic lf, input logic ls, output bit produced, output trainer_result_t r);
		longint x, t, prod, bias_term, sum, pred, err, mag, tol_l, rate_l, step, feat_l, delta, w_l;
		logic [63:0] sq, room;
		logic [COST_W-1:0] diff;
		bit upd;
		r = '0;
		produced = 1'b0;
		x = fv;
		if (m_pos < clamped_count()) begin
			m_buffer[m_pos] = fv;
			prod = x * m_weight[m_pos];
			m_dot = m_dot + prod;
			m_pos++;
		end
		if (!lf)
			return;
		bias_term = m_bias;
		bias_term = bias_term <<< 8;
		sum = $signed(m_dot) + bias_term;
		pred = clamp_word(sum >>> 8);
		t = tgt;
		err = clamp_word(t * 256 - pred);
		mag = (err < 0) ? -err : err;
		tol_l = m_tol;
		upd = (mag > tol_l);
		if (upd) begin
			rate_l = m_rate;
			step = (rate_l * err) >>> 16;
			for (int k = 0; k < m_pos; k++) begin
				feat_l = m_buffer[k];
				delta = (step * feat_l) >>> 8;
				w_l = m_weight[k];
				m_weight[k] = clamp_word(w_l + delta);
			end
			if (m_updates != 32'hffff_ffff)
				m_updates++;
		end
		sq = mag * mag;
		sq = sq >> 17;
		room = {16'd0, COST_FULL - m_run_cost};
		if (sq > room)
			m_run_cost = COST_FULL;
		else
			m_run_cost = m_run_cost + sq[COST_W-1:0];
		if (ls) begin
			diff = (m_run_cost > m_prev_cost) ? m_run_cost - m_prev_cost : m_prev_cost - m_run_cost;
			r.cost_settled = (diff <= m_tol);
			r.pass_cost = m_run_cost;
			m_prev_cost = m_run_cost;
			m_run_cost = '0;
		end
		m_pos = 0;
		m_dot = '0;
		r.prediction = pred[31:0];
		r.error = err[31:0];
		r.weights_updated = upd;
		r.update_count = m_updates;
		produced = 1'b1;
	endtask

	function automatic plan_row_t item_row(input logic [15:0] fv, input logic [15:0] tgt,
			input logic lf, input logic ls);
		plan_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.feature = fv;
		r.target = tgt;
		r.last_f = lf;
		r.last_s = ls;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		plan_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.reg_index = idx;
		r.reg_data = data;
		return r;
	endfunction

	function automatic plan_row_t checked_row(input logic [15:0] fv, input logic [15:0] tgt,
			input logic lf, input logic ls, input logic [31:0] pred, input logic [31:0] err,
			input logic upd, input logic [31:0] count, input logic [COST_W-1:0] cost,
			input logic settled);
		plan_row_t r;
		r = item_row(fv, tgt, lf, ls);
		r.typed = 1'b1;
		r.result.prediction = pred;
		r.result.error = err;
		r.result.weights_updated = upd;
		r.result.update_count = count;
		r.result.pass_cost = cost;
		r.result.cost_settled = settled;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, want_v, got_v);
			mismatches++;
		end
	endtask

	// one input transaction, predicted when accepted
	task automatic send_feature(input logic [15:0] fv, input logic [15:0] tgt, input logic lf,
			input logic ls, input bit typed, input trainer_result_t typed_result);
		int gap;
		bit produced;
		trainer_result_t got;
		cfg_valid <= 1'b0;
		gap = burst_mode ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		feature_value <= fv;
		target <= tgt;
		last_feature <= lf;
		last_sample <= ls;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		train_step(fv, tgt, lf, ls, produced, got);
		if (produced)
			expected_results.push_back(typed ? typed_result : got);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
		reg_writes++;
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: random stall per transaction and checking
	always @(posedge clk) begin : result_sink
		trainer_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result transaction with no pending expectation");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				compare_field("prediction", want.prediction, prediction);
				compare_field("error", want.error, error);
				compare_field("weights_updated", want.weights_updated, weights_updated);
				compare_field("update_count", want.update_count, update_count);
				compare_field("pass_cost", want.pass_cost, pass_cost);
				compare_field("cost_settled", want.cost_settled, cost_settled);
			end
			sink_hold = burst_mode ? 0 : $urandom_range(0, 15);
		end else if (sink_hold > 0) begin
			sink_hold--;
		end
		out_stall <= (sink_hold != 0);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		bit pending;
		bit first;
		int n, nf, passes, samples;
		logic [31:0] data;
		logic [15:0] fv, tgt;
		logic lf, ls;

		// after reset, weights zero
		directed_plan.push_back(checked_row(16'h7fff, 16'h7fff, 1, 0,
			32'd0, 32'd8388352, 1, 32'd1, '0, 0));
		directed_plan.push_back(checked_row(16'h0000, 16'h0000, 1, 1,
			32'd0, 32'd0, 0, 32'd1, 48'd536838144, 0));
		// bias at minimum, no updates, pass cost saturates
		directed_plan.push_back(cfg_row(CFG_TOLERANCE, 32'hffff_ffff));
		directed_plan.push_back(cfg_row(CFG_BIAS, 32'h8000_0000));
		directed_plan.push_back(cfg_row(CFG_FEATURES_IN_USE, 32'd1));
		for (int k = 0; k < 8; k++)
			directed_plan.push_back(checked_row(16'h0000, 16'h7fff, 1, 0,
				32'h8000_0000, 32'h7fff_ffff, 0, 32'd1, '0, 0));
		directed_plan.push_back(checked_row(16'h0000, 16'h7fff, 1, 1,
			32'h8000_0000, 32'h7fff_ffff, 0, 32'd1, COST_FULL, 0));
		// bias at maximum, full rate, feature count of zero clamps to one
		directed_plan.push_back(cfg_row(CFG_TOLERANCE, 32'd0));
		directed_plan.push_back(cfg_row(CFG_BIAS, 32'h7fff_ffff));
		directed_plan.push_back(cfg_row(CFG_LEARNING_RATE, 32'h0000_ffff));
		directed_plan.push_back(cfg_row(CFG_FEATURES_IN_USE, 32'hffff_ffe0));
		directed_plan.push_back(item_row(16'h8000, 16'h8000, 0, 1));
		directed_plan.push_back(item_row(16'h7fff, 16'h8000, 1, 0));
		// count above the buffer depth, sample shorter than the count
		directed_plan.push_back(cfg_row(CFG_FEATURES_IN_USE, 32'd31));
		directed_plan.push_back(item_row(16'h7fff, 16'h1234, 0, 0));
		directed_plan.push_back(item_row(16'h8000, 16'h4321, 0, 0));
		directed_plan.push_back(item_row(16'h0001, 16'h7fff, 1, 1));
		directed_plan.push_back(cfg_row(CFG_LEARNING_RATE, 32'd0));
		directed_plan.push_back(cfg_row(CFG_FEATURES_IN_USE, 32'd17));
		directed_plan.push_back(item_row(16'h5a5a, 16'h0000, 0, 0));
		directed_plan.push_back(item_row(16'ha5a5, 16'h0000, 1, 1));
		// more features than the count
		directed_plan.push_back(cfg_row(CFG_TOLERANCE, 32'd5));
		directed_plan.push_back(cfg_row(CFG_BIAS, 32'd0));
		directed_plan.push_back(cfg_row(CFG_LEARNING_RATE, 32'd655));
		directed_plan.push_back(cfg_row(CFG_FEATURES_IN_USE, 32'd2));
		directed_plan.push_back(item_row(16'h0100, 16'h0000, 0, 0));
		directed_plan.push_back(item_row(16'hff00, 16'h0000, 0, 0));
		directed_plan.push_back(item_row(16'h1234, 16'h0000, 0, 0));
		directed_plan.push_back(item_row(16'h4321, 16'h0100, 1, 1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending = 1'b0;
		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_CFG) begin
				if (pending)
					quiesce();
				pending = 1'b0;
				write_reg(directed_plan[i].reg_index, directed_plan[i].reg_data);
			end else begin
				send_feature(directed_plan[i].feature, directed_plan[i].target,
					directed_plan[i].last_f, directed_plan[i].last_s,
					directed_plan[i].typed, directed_plan[i].result);
				pending = 1'b1;
			end
		end

		first = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			quiesce();
			burst_mode = ($urandom_range(0, 3) == 0);
			if (first || $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 4))
					0: data = 32'd0;
					1: data = 32'h0000_ffff;
					2: data = $urandom();
					default: data = $urandom_range(1, 1024);
				endcase
				write_reg(CFG_LEARNING_RATE, data);
			end
			if (first || $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 5))
					0: data = 32'd0;
					1: data = 32'hffff_ffff;
					2: data = $urandom();
					3: data = $urandom_range(0, 65536);
					default: data = $urandom_range(0, 2048);
				endcase
				write_reg(CFG_TOLERANCE, data);
			end
			if (first || $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 4))
					0: data = 32'h8000_0000;
					1: data = 32'h7fff_ffff;
					2: data = $urandom();
					default: data = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
				endcase
				write_reg(CFG_BIAS, data);
			end
			if (first || $urandom_range(0, 2) == 0) begin
				data = $urandom();
				case ($urandom_range(0, 7))
					0: data[4:0] = 5'd0;
					1: data[4:0] = 5'd16;
					2: data[4:0] = 5'd31;
					3: data[4:0] = 5'd17;
					default: data[4:0] = 5'($urandom_range(1, 4));
				endcase
				write_reg(CFG_FEATURES_IN_USE, data);
			end
			first = 1'b0;

			n = clamped_count();
			passes = $urandom_range(1, 3);
			for (int p = 0; p < passes; p++) begin
				samples = $urandom_range(1, 6);
				for (int s = 0; s < samples; s++) begin
					case ($urandom_range(0, 5))
						0: nf = $urandom_range(1, n);
						1: nf = n + $urandom_range(1, 3);
						default: nf = n;
					endcase
					for (int k = 0; k < nf; k++) begin
						lf = (k == nf - 1);
						ls = lf && (s == samples - 1);
						if (!lf && $urandom_range(0, 9) == 0)
							ls = 1'b1;
						case ($urandom_range(0, 7))
							0: fv = 16'h7fff;
							1: fv = 16'h8000;
							2: fv = 16'h0000;
							3, 4: fv = 16'($urandom());
							default: fv = 16'($urandom_range(0, 1023) - 512);
						endcase
						case ($urandom_range(0, 7))
							0: tgt = 16'h7fff;
							1: tgt = 16'h8000;
							default: tgt = 16'($urandom());
						endcase
						send_feature(fv, tgt, lf, ls, 1'b0, '0);
						random_items++;
					end
				end
			end
		end
		quiesce();

		$display("covered %0d input transactions, %0d results, %0d register writes, %0d mismatches",
			items_sent, results_seen, reg_writes, mismatches);
		$display("settings spanned rate, tolerance and bias extremes and clamped feature counts");
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
